### design/phfr_pkg.sv
// Shared constants, types and register codes for the packet header field rewriter.
package phfr_pkg;

   localparam int LENGTH_BITS = 14;
   localparam int FLEN_W      = 14;
   localparam int TOFF_W      = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;

   typedef logic [LENGTH_BITS-1:0] pos_type;
   typedef logic [TOFF_W-1:0]      toff_type;

   localparam pos_type POS_MAX = {LENGTH_BITS{1'b1}};

   // register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE_MASK  = 3'd0,
      CSR_MAC_DST      = 3'd1,
      CSR_MAC_SRC      = 3'd2,
      CSR_IP_SRC       = 3'd3,
      CSR_IP_DST       = 3'd4,
      CSR_TCP_PORTS    = 3'd5,
      CSR_UDP_PORTS    = 3'd6,
      CSR_SMALL_FIELDS = 3'd7
   } csr_index_type;

   // enable mask bits
   localparam int EN_ETH_DST  = 0;
   localparam int EN_ETH_SRC  = 1;
   localparam int EN_ETYPE    = 2;
   localparam int EN_PROTO    = 3;
   localparam int EN_IP_SRC   = 4;
   localparam int EN_IP_DST   = 5;
   localparam int EN_DSCP     = 6;
   localparam int EN_TTL      = 7;
   localparam int EN_ECN      = 8;
   localparam int EN_TCP_SRC  = 9;
   localparam int EN_TCP_DST  = 10;
   localparam int EN_UDP_SRC  = 11;
   localparam int EN_UDP_DST  = 12;
   localparam int MASK_W      = 13;

   typedef enum logic [1:0] {
      LAYER_NONE = 2'd0,
      LAYER_IPV4 = 2'd1,
      LAYER_IPV6 = 2'd2
   } layer_type;

   localparam logic [7:0]  TPID_HIGH    = 8'h81;
   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [7:0]  TOS_ECN_MASK = 8'h03;
   localparam logic [7:0]  TOS_DSCP_MASK = 8'hFC;
   localparam logic [3:0]  IHL_MIN      = 4'd5;

   localparam int NET_PLAIN   = 14;
   localparam int NET_TAGGED  = 18;
   localparam int IPV4_HDR    = 20;
   localparam int IPV6_HDR    = 40;
   localparam int IPV6_SCAN   = 8;
   localparam int PORT_BYTES  = 4;
   localparam int XPORT_MIN   = 8;

   typedef struct packed {
      logic [MASK_W-1:0] enable_mask;
      logic [47:0]       mac_destination;
      logic [47:0]       mac_source;
      logic [31:0]       ip_source;
      logic [31:0]       ip_destination;
      logic [31:0]       tcp_port_pair;
      logic [31:0]       udp_port_pair;
      logic [39:0]       small_fields;
   } cfg_type;

endpackage

### design/phfr_csr.sv
// Configuration register bank for the header rewriter.
module phfr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [phfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [phfr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output phfr_pkg::cfg_type                   cfg
);

   phfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (phfr_pkg::csr_index_type'(csr_index))
            phfr_pkg::CSR_ENABLE_MASK:
               cfg_in.enable_mask = csr_wdata[phfr_pkg::MASK_W-1:0];
            phfr_pkg::CSR_MAC_DST:      cfg_in.mac_destination = csr_wdata[47:0];
            phfr_pkg::CSR_MAC_SRC:      cfg_in.mac_source      = csr_wdata[47:0];
            phfr_pkg::CSR_IP_SRC:       cfg_in.ip_source       = csr_wdata[31:0];
            phfr_pkg::CSR_IP_DST:       cfg_in.ip_destination  = csr_wdata[31:0];
            phfr_pkg::CSR_TCP_PORTS:    cfg_in.tcp_port_pair   = csr_wdata[31:0];
            phfr_pkg::CSR_UDP_PORTS:    cfg_in.udp_port_pair   = csr_wdata[31:0];
            phfr_pkg::CSR_SMALL_FIELDS: cfg_in.small_fields    = csr_wdata[39:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/phfr_core.sv
// Frame parser state and per-byte field replacement logic.
module phfr_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [7:0]                     data_byte,
   input  logic                           first_byte,
   input  logic                           last_byte,
   input  logic [phfr_pkg::FLEN_W-1:0]    frame_length,
   input  phfr_pkg::cfg_type              cfg,
   output logic [7:0]                     out_byte
);

   phfr_pkg::pos_type    pos_ff, pos_in, fb_ff, fb_in;
   logic                 vlan_ff, vlan_in;
   logic [7:0]           thi_ff, thi_in;
   phfr_pkg::layer_type  layer_ff, layer_in;
   logic [3:0]           hw_ff, hw_in;
   logic [7:0]           proto_ff, proto_in;
   logic                 lfrag_ff, lfrag_in;
   phfr_pkg::toff_type   toff_ff, toff_in;
   logic                 ocand_ff, ocand_in;
   logic                 inner_ff, inner_in;

   // effective values for this byte (a first marker clears the frame)
   phfr_pkg::pos_type    pos, fb, net, kpos, jpos, flen_sat;
   logic                 e_vlan, e_ocand, e_inner, e_lfrag;
   logic [7:0]           e_thi, e_proto;
   phfr_pkg::layer_type  e_layer;
   logic [3:0]           e_hw;
   phfr_pkg::toff_type   e_toff;
   // next values after this byte
   logic                 n_vlan, n_ocand, n_inner, n_lfrag;
   logic [7:0]           n_thi, n_proto;
   phfr_pkg::layer_type  n_layer;
   logic [3:0]           n_hw;
   phfr_pkg::toff_type   n_toff;

   logic [7:0]           o, d;
   logic [15:0]          etype;
   logic [31:0]          pair;
   logic                 sbit, dbit, port_hit;
   logic [4:0]           k;
   logic [16:0]          flen_x;

   function automatic phfr_pkg::layer_type classify(logic [7:0] hi, logic [7:0] lo);
      logic [15:0] t;
      t = {hi, lo};
      if (t == phfr_pkg::ETYPE_IPV4)      return phfr_pkg::LAYER_IPV4;
      else if (t == phfr_pkg::ETYPE_IPV6) return phfr_pkg::LAYER_IPV6;
      else                                return phfr_pkg::LAYER_NONE;
   endfunction

   always_comb begin
      d        = data_byte;
      etype    = cfg.small_fields[39:24];
      flen_x   = 17'(frame_length);
      flen_sat = (flen_x > 17'(phfr_pkg::POS_MAX)) ? phfr_pkg::POS_MAX
                                                   : phfr_pkg::pos_type'(frame_length);

      pos      = first_byte ? '0 : pos_ff;
      fb       = first_byte ? flen_sat : fb_ff;
      e_vlan   = first_byte ? 1'b0 : vlan_ff;
      e_thi    = first_byte ? '0 : thi_ff;
      e_layer  = first_byte ? phfr_pkg::LAYER_NONE : layer_ff;
      e_hw     = first_byte ? '0 : hw_ff;
      e_proto  = first_byte ? '0 : proto_ff;
      e_lfrag  = first_byte ? 1'b0 : lfrag_ff;
      e_toff   = first_byte ? '0 : toff_ff;
      e_ocand  = first_byte ? 1'b0 : ocand_ff;
      e_inner  = first_byte ? 1'b0 : inner_ff;

      n_vlan = e_vlan;   n_thi = e_thi;     n_layer = e_layer; n_hw = e_hw;
      n_proto = e_proto; n_lfrag = e_lfrag; n_toff = e_toff;
      n_ocand = e_ocand; n_inner = e_inner;

      net  = e_vlan ? phfr_pkg::pos_type'(phfr_pkg::NET_TAGGED)
                    : phfr_pkg::pos_type'(phfr_pkg::NET_PLAIN);
      kpos = pos - net;
      k    = kpos[4:0];
      o    = d;

      priority if (pos < phfr_pkg::pos_type'(6)) begin
         if (cfg.enable_mask[phfr_pkg::EN_ETH_DST])
            o = cfg.mac_destination[8*(3'(3'd5 - pos[2:0])) +: 8];
      end else if (pos < phfr_pkg::pos_type'(12)) begin
         if (cfg.enable_mask[phfr_pkg::EN_ETH_SRC])
            o = cfg.mac_source[8*(3'(4'd11 - pos[3:0])) +: 8];
      end else if (pos == phfr_pkg::pos_type'(12)) begin
         n_ocand = (d == phfr_pkg::TPID_HIGH);
         if (cfg.enable_mask[phfr_pkg::EN_ETYPE] && !n_ocand) o = etype[15:8];
         n_thi = o;
      end else if (pos == phfr_pkg::pos_type'(13)) begin
         // tag judged on the original outer type
         n_inner = e_ocand && (d == 8'h00);
         if (cfg.enable_mask[phfr_pkg::EN_ETYPE] && !n_inner) o = etype[7:0];
         n_vlan = (e_thi == phfr_pkg::TPID_HIGH) && (o == 8'h00);
         if (!n_vlan) n_layer = classify(e_thi, o);
      end else if (e_vlan && pos == phfr_pkg::pos_type'(16)) begin
         if (cfg.enable_mask[phfr_pkg::EN_ETYPE] && e_inner) o = etype[15:8];
         n_thi = o;
      end else if (e_vlan && pos == phfr_pkg::pos_type'(17)) begin
         if (cfg.enable_mask[phfr_pkg::EN_ETYPE] && e_inner) o = etype[7:0];
         n_layer = classify(e_thi, o);
      end else if (e_layer == phfr_pkg::LAYER_IPV4 && pos >= net &&
                   pos < net + phfr_pkg::pos_type'(phfr_pkg::IPV4_HDR)) begin
         priority if (k == 5'd0) begin
            n_hw   = d[3:0];
            n_toff = phfr_pkg::toff_type'(net) + phfr_pkg::toff_type'({d[3:0], 2'b00});
         end else if (k == 5'd1) begin
            if (cfg.enable_mask[phfr_pkg::EN_DSCP])
               o = (o & phfr_pkg::TOS_ECN_MASK) |
                   (cfg.small_fields[7:0] & phfr_pkg::TOS_DSCP_MASK);
            if (cfg.enable_mask[phfr_pkg::EN_ECN])
               o = (o & phfr_pkg::TOS_DSCP_MASK) |
                   (cfg.small_fields[7:0] & phfr_pkg::TOS_ECN_MASK);
         end else if (k == 5'd6) begin
            n_lfrag = (d[4:0] != 5'd0);
         end else if (k == 5'd7) begin
            if (d != 8'h00) n_lfrag = 1'b1;
         end else if (k == 5'd8) begin
            if (cfg.enable_mask[phfr_pkg::EN_TTL]) o = cfg.small_fields[15:8];
         end else if (k == 5'd9) begin
            if (cfg.enable_mask[phfr_pkg::EN_PROTO]) o = cfg.small_fields[23:16];
            n_proto = o;
         end else if (k >= 5'd12 && k < 5'd16) begin
            if (cfg.enable_mask[phfr_pkg::EN_IP_SRC])
               o = cfg.ip_source[8*(2'(2'd3 - k[1:0])) +: 8];
         end else if (k >= 5'd16) begin
            if (cfg.enable_mask[phfr_pkg::EN_IP_DST])
               o = cfg.ip_destination[8*(2'(2'd3 - k[1:0])) +: 8];
         end else begin
            o = o;
         end
      end else if (e_layer == phfr_pkg::LAYER_IPV6 && pos >= net &&
                   pos < net + phfr_pkg::pos_type'(phfr_pkg::IPV6_SCAN)) begin
         if (k == 5'd0)
            n_toff = phfr_pkg::toff_type'(net) + phfr_pkg::toff_type'(phfr_pkg::IPV6_HDR);
         else if (k == 5'd6)
            n_proto = d;
      end else begin
         o = o;
      end

      // transport ports, judged on the state as left by this byte
      jpos = pos - phfr_pkg::pos_type'(n_toff);
      if (n_proto == phfr_pkg::PROTO_TCP) begin
         sbit = cfg.enable_mask[phfr_pkg::EN_TCP_SRC];
         dbit = cfg.enable_mask[phfr_pkg::EN_TCP_DST];
         pair = cfg.tcp_port_pair;
      end else if (n_proto == phfr_pkg::PROTO_UDP) begin
         sbit = cfg.enable_mask[phfr_pkg::EN_UDP_SRC];
         dbit = cfg.enable_mask[phfr_pkg::EN_UDP_DST];
         pair = cfg.udp_port_pair;
      end else begin
         sbit = 1'b0;
         dbit = 1'b0;
         pair = '0;
      end
      port_hit = (n_layer != phfr_pkg::LAYER_NONE) && (n_toff != '0) &&
                 (pos >= phfr_pkg::pos_type'(n_toff)) &&
                 (pos < phfr_pkg::pos_type'(n_toff) +
                        phfr_pkg::pos_type'(phfr_pkg::PORT_BYTES)) &&
                 (fb >= phfr_pkg::pos_type'(n_toff) +
                        phfr_pkg::pos_type'(phfr_pkg::XPORT_MIN)) &&
                 ((n_layer == phfr_pkg::LAYER_IPV6) ||
                  (!n_lfrag && n_hw >= phfr_pkg::IHL_MIN));
      if (port_hit && (jpos[1] ? dbit : sbit))
         o = pair[8*(2'(2'd3 - jpos[1:0])) +: 8];

      // next state: a last marker ends the frame
      if (last_byte) begin
         pos_in = '0;  fb_in = '0;
         vlan_in = 1'b0; thi_in = '0; layer_in = phfr_pkg::LAYER_NONE; hw_in = '0;
         proto_in = '0; lfrag_in = 1'b0; toff_in = '0; ocand_in = 1'b0; inner_in = 1'b0;
      end else begin
         pos_in = (pos < phfr_pkg::POS_MAX) ? pos + phfr_pkg::pos_type'(1) : phfr_pkg::POS_MAX;
         fb_in = fb;
         vlan_in = n_vlan; thi_in = n_thi; layer_in = n_layer; hw_in = n_hw;
         proto_in = n_proto; lfrag_in = n_lfrag; toff_in = n_toff;
         ocand_in = n_ocand; inner_in = n_inner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;  fb_ff <= '0;  vlan_ff <= 1'b0;  thi_ff <= '0;
         layer_ff <= phfr_pkg::LAYER_NONE;  hw_ff <= '0;  proto_ff <= '0;
         lfrag_ff <= 1'b0;  toff_ff <= '0;  ocand_ff <= 1'b0;  inner_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in;  fb_ff <= fb_in;  vlan_ff <= vlan_in;  thi_ff <= thi_in;
         layer_ff <= layer_in;  hw_ff <= hw_in;  proto_ff <= proto_in;
         lfrag_ff <= lfrag_in;  toff_ff <= toff_in;  ocand_ff <= ocand_in;
         inner_ff <= inner_in;
      end
   end

   assign out_byte = o;

endmodule

### design/packet_header_field_rewriter.sv
// Top level of the streaming Ethernet header field rewriter.
// Frames enter one byte per transfer and leave one byte per transfer, in order, with
// the enabled MAC, ethertype, IPv4 and TCP/UDP port fields replaced by the configured
// values (checksums untouched). Each byte passes from input transfer to result through
// the input register, then through the parser and replacement logic into the result
// register. A new byte is taken every cycle while the result side keeps up; the result
// register lets the next byte be taken while a finished one waits. The user must
// write configuration registers only while no frame bytes are in flight; not enforced.
module packet_header_field_rewriter (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_first_byte,
   input  logic                              req_last_byte,
   input  logic [phfr_pkg::FLEN_W-1:0]       req_frame_length,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_out_last,
   // configuration port
   input  logic                              csr_write,
   input  logic [phfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [phfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   phfr_pkg::cfg_type             cfg;

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [7:0]                    s1_data_ff;
   logic                          s1_first_ff, s1_last_ff;
   logic [phfr_pkg::FLEN_W-1:0]   s1_flen_ff;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [7:0]                    out_byte_ff;
   logic                          out_last_ff;

   logic                          accept, advance;
   logic [7:0]                    new_byte;

   // a byte moves to the result register when that register is empty or is being emptied
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   phfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // parser state advances once per byte, as it leaves the input register
   phfr_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (s1_data_ff),
      .first_byte   (s1_first_ff),
      .last_byte    (s1_last_ff),
      .frame_length (s1_flen_ff),
      .cfg          (cfg),
      .out_byte     (new_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff  <= req_data_byte;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
         s1_flen_ff  <= req_frame_length;
      end
      if (advance) begin
         out_byte_ff <= new_byte;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

   // a held byte behind a stalled result must stall the input side
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages are full");

   // a result only appears after a byte sat in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a byte in flight");

   // a transfer out with nothing behind it empties the result register
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_stall && !s1_valid_ff |=> !rsp_valid)
      else $error("result repeated after its transfer");

endmodule
